FILE: hw/rtl/whdr_pkg.sv
// ----------------------------------------------------------------------------
// whdr_pkg
// Shared types, codes and helpers for the wheel delta to HID report core.
// ----------------------------------------------------------------------------
package whdr_pkg;

  localparam int unsigned DeltaW   = 16;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned MoveW    = 4;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ZoomW    = 8;
  localparam int unsigned StepW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // wheel modes
  localparam logic [ModeW-1:0] ModeScroll = 3'd0;
  localparam logic [ModeW-1:0] ModePan    = 3'd1;
  localparam logic [ModeW-1:0] ModeZoom   = 3'd2;
  localparam logic [ModeW-1:0] ModeVolume = 3'd3;
  localparam logic [ModeW-1:0] ModeSelect = 3'd4;

  // report kinds
  localparam logic [KindW-1:0] KindNone   = 2'd0;
  localparam logic [KindW-1:0] KindMouse  = 2'd1;
  localparam logic [KindW-1:0] KindVolume = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegZoomDivisor = 1'd0;
  localparam logic [CfgIdxW-1:0] RegVolumeStep  = 1'd1;

  localparam logic [ZoomW-1:0] ZoomDivisorReset = 8'd4;
  localparam logic [StepW-1:0] VolumeStepReset  = 16'd4;

  localparam logic signed [MoveW-1:0] MoveUp   = 4'sd5;
  localparam logic signed [MoveW-1:0] MoveDown = -4'sd5;

  typedef struct packed {
    logic signed [DeltaW-1:0] delta;
    logic [ModeW-1:0]         mode;
    logic [TimeW-1:0]         now_ms;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]         report_kind;
    logic                     left_button;
    logic signed [MoveW-1:0]  move_y;
    logic signed [DeltaW-1:0] wheel;
    logic signed [DeltaW-1:0] pan;
    logic                     volume_down;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_step;
    logic acc_add;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             delta_zero;
    logic [ModeW-1:0] mode;
  } status_t;

  // negate with saturation to the 16-bit signed range
  function automatic logic signed [DeltaW-1:0] neg_sat16(input logic signed [DeltaW-1:0] v);
    logic signed [DeltaW-1:0] r;
    if (v == {1'b1, {(DeltaW-1){1'b0}}}) begin
      r = {1'b0, {(DeltaW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/wheel_delta_to_hid_report_core.sv
// ----------------------------------------------------------------------------
// wheel_delta_to_hid_report_core
// Turns wheel deltas into mouse reports or consumer volume clicks.
// ----------------------------------------------------------------------------
// One item is in work at a time, and each item gives exactly one result beat
// (report_kind none when nothing is sent). In scroll, pan and select mode and
// for a zero delta the item passes decode, then result; in volume mode it
// passes decode, accumulate, then click check; in zoom mode it passes decode,
// then a serial divider that produces one quotient bit per cycle for the
// 16-bit delta magnitude, then result. The input is free again in the cycle
// after the result is written. A new item is taken while the previous result
// still waits in the output register; the result register only stalls the
// core when a second result is ready before the first has been taken.
// Configuration writes go through the plain write port and must only be
// issued while the core is idle.
module wheel_delta_to_hid_report_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  whdr_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output whdr_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [whdr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [whdr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  whdr_pkg::cmd_t    cmd;
  whdr_pkg::status_t status;

  whdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  whdr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

FILE: hw/rtl/whdr_div.sv
// ----------------------------------------------------------------------------
// whdr_div
// Restoring serial divider: one quotient bit of the delta magnitude per step.
// ----------------------------------------------------------------------------
module whdr_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [whdr_pkg::DeltaW-1:0]    dividend_i,
  input  logic [whdr_pkg::ZoomW-1:0]     divisor_i,
  output logic [whdr_pkg::DeltaW-1:0]    quotient_o
);

  logic [whdr_pkg::ZoomW:0]       rem_q, rem_d;
  logic [whdr_pkg::DeltaW-1:0]    quot_q, quot_d;
  logic [whdr_pkg::ZoomW:0]       shifted;
  logic [whdr_pkg::ZoomW:0]       div_ext;
  logic                           fits;

  always_comb begin
    // a zero divisor acts as one
    div_ext = (divisor_i == '0) ? {{whdr_pkg::ZoomW{1'b0}}, 1'b1} : {1'b0, divisor_i};
    shifted = {rem_q[whdr_pkg::ZoomW-1:0], quot_q[whdr_pkg::DeltaW-1]};
    fits    = (shifted >= div_ext);
    rem_d   = rem_q;
    quot_d  = quot_q;
    if (load_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
    end else if (step_i) begin
      rem_d  = fits ? (shifted - div_ext) : shifted;
      quot_d = {quot_q[whdr_pkg::DeltaW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quotient_o = quot_q;

endmodule

FILE: hw/rtl/whdr_dpath.sv
// ----------------------------------------------------------------------------
// whdr_dpath
// Datapath: input and config registers, divider, volume accumulator and the
// result register.
// ----------------------------------------------------------------------------
module whdr_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  whdr_pkg::cmd_t                  cmd_i,
  output whdr_pkg::status_t               status_o,
  input  whdr_pkg::in_item_t              in_data_i,
  output whdr_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [whdr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [whdr_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned AccW = whdr_pkg::AccW;
  localparam int unsigned DW   = whdr_pkg::DeltaW;

  whdr_pkg::in_item_t           item_q;
  whdr_pkg::out_item_t          out_q, res;
  logic [whdr_pkg::ZoomW-1:0]   zoom_q;
  logic [whdr_pkg::StepW-1:0]   vstep_q;
  logic signed [AccW-1:0]       acc_q, acc_d;
  logic [whdr_pkg::TimeW-1:0]   next_ms_q, next_ms_d;
  logic                         phase_q, phase_d;

  logic [DW-1:0]                in_mag;
  logic [DW-1:0]                quot;
  logic signed [AccW:0]         acc_ext, sum, diff, sum_step, step_ext;
  logic signed [AccW-1:0]       acc_sat;
  logic                         time_ok, ge_step, le_nstep, click_try;
  logic signed [DW-1:0]         zoom_wheel;

  assign in_mag = in_data_i.delta[DW-1] ? (~in_data_i.delta + 1'b1) : in_data_i.delta;

  whdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.load_in),
    .step_i     (cmd_i.div_step),
    .dividend_i (in_mag),
    .divisor_i  (zoom_q),
    .quotient_o (quot)
  );

  assign status_o.delta_zero = (item_q.delta == '0);
  assign status_o.mode       = item_q.mode;

  always_comb begin
    acc_ext  = {acc_q[AccW-1], acc_q};
    sum      = acc_ext + {{(AccW+1-DW){item_q.delta[DW-1]}}, item_q.delta};
    // saturate when the two top bits disagree
    if (sum[AccW] != sum[AccW-1]) begin
      acc_sat = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = sum[AccW-1:0];
    end
    step_ext = (vstep_q == '0) ? {{AccW{1'b0}}, 1'b1}
                               : {{(AccW+1-whdr_pkg::StepW){1'b0}}, vstep_q};
    diff     = acc_ext - step_ext;
    sum_step = acc_ext + step_ext;
    ge_step  = !diff[AccW];
    le_nstep = sum_step[AccW] || (sum_step == '0);
    time_ok  = (item_q.now_ms >= next_ms_q);
  end

  // zoom quotient: sign follows delta, then negated with saturation
  always_comb begin
    if (item_q.delta[DW-1]) begin
      zoom_wheel = quot[DW-1] ? {1'b0, {(DW-1){1'b1}}} : quot;
    end else begin
      zoom_wheel = -quot;
    end
  end

  always_comb begin
    res       = '0;
    acc_d     = acc_q;
    next_ms_d = next_ms_q;
    phase_d   = phase_q;
    click_try = 1'b0;
    if (cmd_i.acc_add) begin
      acc_d = acc_sat;
    end
    if (item_q.delta == '0) begin
      click_try = 1'b1;
    end else begin
      case (item_q.mode)
        whdr_pkg::ModeScroll: begin
          res.report_kind = whdr_pkg::KindMouse;
          res.wheel       = whdr_pkg::neg_sat16(item_q.delta);
        end
        whdr_pkg::ModePan: begin
          res.report_kind = whdr_pkg::KindMouse;
          res.pan         = item_q.delta;
        end
        whdr_pkg::ModeZoom: begin
          if (quot != '0) begin
            res.report_kind = whdr_pkg::KindMouse;
            res.wheel       = zoom_wheel;
          end
        end
        whdr_pkg::ModeVolume: begin
          click_try = 1'b1;
        end
        whdr_pkg::ModeSelect: begin
          res.report_kind = whdr_pkg::KindMouse;
          res.left_button = 1'b1;
          res.move_y      = phase_q ? whdr_pkg::MoveUp : whdr_pkg::MoveDown;
          res.wheel       = whdr_pkg::neg_sat16(item_q.delta);
          if (cmd_i.finish) begin
            phase_d = !phase_q;
          end
        end
        default: begin
        end
      endcase
    end
    if (click_try && time_ok && (ge_step || le_nstep)) begin
      res.report_kind = whdr_pkg::KindVolume;
      res.volume_down = ge_step;
      if (cmd_i.finish) begin
        acc_d     = ge_step ? diff[AccW-1:0] : sum_step[AccW-1:0];
        next_ms_d = item_q.now_ms + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q    <= whdr_pkg::ZoomDivisorReset;
      vstep_q   <= whdr_pkg::VolumeStepReset;
      acc_q     <= '0;
      next_ms_q <= '0;
      phase_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          whdr_pkg::RegZoomDivisor: zoom_q  <= cfg_wdata_i[whdr_pkg::ZoomW-1:0];
          whdr_pkg::RegVolumeStep:  vstep_q <= cfg_wdata_i[whdr_pkg::StepW-1:0];
          default: begin
          end
        endcase
      end
      acc_q     <= acc_d;
      next_ms_q <= next_ms_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_data_i;
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/whdr_ctrl.sv
// ----------------------------------------------------------------------------
// whdr_ctrl
// Controller: sequences decode, division steps, accumulation and the
// result beat, and owns the output valid flag.
// ----------------------------------------------------------------------------
module whdr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  whdr_pkg::status_t    status_i,
  output whdr_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StDiv    = 3'd2;
  localparam logic [2:0] StAccum  = 3'd3;
  localparam logic [2:0] StFinish = 3'd4;

  localparam int unsigned CntW = $clog2(whdr_pkg::DeltaW);

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cnt_d = '0;
        if (status_i.delta_zero) begin
          state_d = StFinish;
        end else if (status_i.mode == whdr_pkg::ModeZoom) begin
          state_d = StDiv;
        end else if (status_i.mode == whdr_pkg::ModeVolume) begin
          state_d = StAccum;
        end else begin
          state_d = StFinish;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == {CntW{1'b1}}) begin
          state_d = StFinish;
        end
      end
      StAccum: begin
        cmd_o.acc_add = 1'b1;
        state_d       = StFinish;
      end
      StFinish: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wheel delta to HID report core. A directed
// table covers field extremes, every mode and the corner cases, then random
// mode runs under several divisor/step settings, and a final back-to-back
// burst of full-scale volume beats followed by draining clicks. Each result
// beat is compared against its table entry or an in-bench model of the converter.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whdr_pkg::*;

  // modes with no defined behaviour
  localparam logic [ModeW-1:0] ModeSpare5 = 3'd5;
  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

  localparam int PhaseItems   = 320;
  localparam int NumPhases    = 6;
  localparam int BurstItems   = 20;
  localparam int SettleCycles = 30;
  localparam int AccMax       = 2147483647;

  localparam out_item_t NoReport = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // converter model state
  logic [ZoomW-1:0] zoom_div;
  logic [StepW-1:0] vol_step;
  int               vol_acc;
  logic [TimeW-1:0] next_click;
  logic             sel_phase;

  out_item_t expected_reports[$];
  int        fail_count = 0;

  // random stimulus state
  logic [ModeW-1:0] run_mode = ModeScroll;
  int               run_left = 0;
  logic [TimeW-1:0] clock_ms = '0;
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;
  int               stall_left = 0;

  stim_row_t directed_rows [24] = '{
    '{'{16'sd0,      ModeScroll, 32'd0},  1'b1, NoReport},
    '{'{16'sd1,      ModeScroll, 32'd0},  1'b1,
      '{KindMouse, 1'b0, 4'sd0, -16'sd1, 16'sd0, 1'b0}},
    '{'{16'sh8000,   ModeScroll, 32'd0},  1'b1,
      '{KindMouse, 1'b0, 4'sd0, 16'sh7fff, 16'sd0, 1'b0}},
    '{'{16'sh7fff,   ModeScroll, 32'd5},  1'b1,
      '{KindMouse, 1'b0, 4'sd0, 16'sh8001, 16'sd0, 1'b0}},
    '{'{16'sh8000,   ModePan,    32'd6},  1'b1,
      '{KindMouse, 1'b0, 4'sd0, 16'sd0, 16'sh8000, 1'b0}},
    '{'{16'sh7fff,   ModePan,    32'd7},  1'b1,
      '{KindMouse, 1'b0, 4'sd0, 16'sd0, 16'sh7fff, 1'b0}},
    '{'{-16'sd1,     ModePan,    32'd7},  1'b0, NoReport},
    '{'{16'sd7,      ModeZoom,   32'd8},  1'b0, NoReport},
    '{'{16'sd3,      ModeZoom,   32'd8},  1'b0, NoReport},
    '{'{16'sh8000,   ModeZoom,   32'd8},  1'b0, NoReport},
    '{'{-16'sd9,     ModeZoom,   32'd9},  1'b0, NoReport},
    '{'{16'sh7fff,   ModeZoom,   32'd9},  1'b0, NoReport},
    '{'{16'sd3,      ModeSelect, 32'd10}, 1'b1,
      '{KindMouse, 1'b1, MoveDown, -16'sd3, 16'sd0, 1'b0}},
    '{'{16'sh8000,   ModeSelect, 32'd10}, 1'b1,
      '{KindMouse, 1'b1, MoveUp, 16'sh7fff, 16'sd0, 1'b0}},
    '{'{16'sd10,     ModeVolume, 32'd20}, 1'b0, NoReport},
    '{'{16'sd1,      ModeVolume, 32'd20}, 1'b0, NoReport},
    '{'{16'sd0,      ModeScroll, 32'd20}, 1'b0, NoReport},
    '{'{16'sd0,      ModePan,    32'd21}, 1'b0, NoReport},
    // click at the top of the time range, next one allowed after the wrap
    '{'{16'sh8000,   ModeVolume, 32'hffff_ffff}, 1'b0, NoReport},
    '{'{16'sd0,      ModeVolume, 32'd0},  1'b0, NoReport},
    '{'{16'sd100,    ModeSpare5, 32'd1},  1'b1, NoReport},
    '{'{-16'sd1,     ModeSpare7, 32'd1},  1'b1, NoReport},
    '{'{16'sd0,      ModeSpare6, 32'd2},  1'b0, NoReport},
    '{'{16'sd1,      ModeSelect, 32'd3},  1'b0, NoReport}
  };

  wheel_delta_to_hid_report_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // negate, clipped to the positive 16-bit limit
  function automatic logic signed [DeltaW-1:0] neg_clip(int v);
    int n;
    n = -v;
    if (n > 32767) n = 32767;
    return DeltaW'(n);
  endfunction

  // one click when the millisecond gate is open and the accumulator holds a step
  function automatic void volume_click(logic [TimeW-1:0] now, inout out_item_t r);
    longint step;
    step = (vol_step == '0) ? 64'sd1 : longint'(vol_step);
    if (now < next_click) return;
    if (longint'(vol_acc) >= step) begin
      vol_acc       = int'(longint'(vol_acc) - step);
      next_click    = now + 32'd1;
      r.report_kind = KindVolume;
      r.volume_down = 1'b1;
    end else if (longint'(vol_acc) <= -step) begin
      vol_acc       = int'(longint'(vol_acc) + step);
      next_click    = now + 32'd1;
      r.report_kind = KindVolume;
      r.volume_down = 1'b0;
    end
  endfunction

  function automatic out_item_t wheel_report(in_item_t it);
    out_item_t r;
    longint    sum;
    int        dv;
    int        q;
    r = NoReport;
    if (it.delta == '0) begin
      volume_click(it.now_ms, r);
      return r;
    end
    case (it.mode)
      ModeScroll: begin
        r.report_kind = KindMouse;
        r.wheel       = neg_clip(int'(it.delta));
      end
      ModePan: begin
        r.report_kind = KindMouse;
        r.pan         = it.delta;
      end
      ModeZoom: begin
        dv = (zoom_div == '0) ? 1 : int'(zoom_div);
        q  = int'(it.delta) / dv;
        if (q != 0) begin
          r.report_kind = KindMouse;
          r.wheel       = neg_clip(q);
        end
      end
      ModeVolume: begin
        sum = longint'(vol_acc) + longint'(it.delta);
        if (sum > AccMax) sum = AccMax;
        if (sum < -longint'(AccMax) - 1) sum = -longint'(AccMax) - 1;
        vol_acc = int'(sum);
        volume_click(it.now_ms, r);
      end
      ModeSelect: begin
        r.report_kind = KindMouse;
        r.left_button = 1'b1;
        r.move_y      = sel_phase ? MoveUp : MoveDown;
        r.wheel       = neg_clip(int'(it.delta));
        sel_phase     = ~sel_phase;
      end
      default: ;
    endcase
    return r;
  endfunction

  // modes come in runs so volume and select sequences build up state
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       small_v;
    if (run_left == 0) begin
      if ($urandom_range(0, 11) == 0) run_mode = ModeW'($urandom_range(5, 7));
      else run_mode = ModeW'($urandom_range(0, 4));
      run_left = $urandom_range(1, 8);
    end
    run_left--;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.delta = '0;
    end else if (pick < 27) begin
      case ($urandom_range(0, 4))
        0: it.delta = 16'sh8000;
        1: it.delta = 16'sh7fff;
        2: it.delta = 16'sh8001;
        3: it.delta = 16'sd1;
        default: it.delta = -16'sd1;
      endcase
    end else if (pick < 75) begin
      small_v  = int'($urandom_range(0, 128)) - 64;
      it.delta = DeltaW'(small_v);
    end else begin
      it.delta = DeltaW'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 5) clock_ms = 32'hffff_fff0 + $urandom_range(0, 15);
    else if (pick < 10) clock_ms = clock_ms - $urandom_range(1, 3);
    else clock_ms = clock_ms + $urandom_range(0, 2);
    it.mode   = run_mode;
    it.now_ms = clock_ms;
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = wheel_report(it);
    expected_reports.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic write_regs(logic [ZoomW-1:0] div, logic [StepW-1:0] step);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegZoomDivisor;
    cfg_wdata_i <= CfgDataW'(div);
    @(posedge clk_i);
    cfg_idx_i   <= RegVolumeStep;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    zoom_div = div;
    vol_step = step;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_reports
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual %p", $time, out_data_o);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("report_kind", int'(want.report_kind), int'(out_data_o.report_kind));
        check_field("left_button", int'(want.left_button), int'(out_data_o.left_button));
        check_field("move_y", int'(want.move_y), int'(out_data_o.move_y));
        check_field("wheel", int'(want.wheel), int'(out_data_o.wheel));
        check_field("pan", int'(want.pan), int'(out_data_o.pan));
        check_field("volume_down", int'(want.volume_down), int'(out_data_o.volume_down));
      end
    end
  end

  initial begin
    logic [TimeW-1:0] sat_ms;
    in_item_t         it;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    zoom_div    = ZoomDivisorReset;
    vol_step    = VolumeStepReset;
    vol_acc     = 0;
    next_click  = '0;
    sel_phase   = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: write_regs(8'd1, 16'd1);
        2: write_regs(8'd255, 16'd65535);
        3: write_regs(8'd0, 16'd0);      // zero acts as one on both
        4: write_regs(ZoomW'($urandom_range(1, 255)), StepW'($urandom_range(1, 16)));
        5: write_regs(8'd3, 16'd2);
        default: ;
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 64 == 0) begin
          tx_idle_en = ($urandom_range(0, 3) != 0);
          rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        send_item(random_item(), 1'b0, NoReport);
        if (i == PhaseItems / 2 || $urandom_range(0, 299) == 0) begin
          wait_idle();
        end else if (tx_idle_en && $urandom_range(0, 4) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
      wait_idle();
    end

    // back-to-back full-scale volume beats at one timestamp build up the
    // accumulator, then zero deltas drain it one click per millisecond
    write_regs(8'd3, 16'd65535);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    sat_ms   = clock_ms;
    for (int k = 0; k < BurstItems; k++) begin
      it = '{delta: 16'sh7fff, mode: ModeVolume, now_ms: sat_ms};
      send_item(it, 1'b0, NoReport);
    end
    for (int k = 1; k <= 16; k++) begin
      it = '{delta: 16'sd0, mode: ModeScroll, now_ms: sat_ms + k};
      send_item(it, 1'b0, NoReport);
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
